### rtl/lgss_pkg.sv
// Package with payload types, function codes and defaults for the state spread block.
`default_nettype none
package lgss_pkg;
  localparam int unsigned VerticesDef  = 256;
  localparam int unsigned MaxDegreeDef = 8;

  localparam logic [2:0] FUNC_NBR   = 3'd0;
  localparam logic [2:0] FUNC_DEG   = 3'd1;
  localparam logic [2:0] FUNC_SET   = 3'd2;
  localparam logic [2:0] FUNC_LOCK  = 3'd3;
  localparam logic [2:0] FUNC_PROP  = 3'd4;
  localparam logic [2:0] FUNC_QUERY = 3'd5;

  typedef struct packed {
    logic [2:0] func;
    logic [7:0] vertex;
    logic [2:0] slot;
    logic [7:0] neighbor;
    logic [3:0] degree_value;
    logic       flag;
  } in_item_t;

  typedef struct packed {
    logic       vertex_on;
    logic       vertex_locked;
    logic [8:0] turned_on_count;
    logic       work_pending;
  } out_item_t;
endpackage
`default_nettype wire

### rtl/lockable_graph_state_spread_top.sv
// Top level of the lockable state spread block: control sequencer and memories.
// One transaction is taken at a time. Load, set, lock, query and unused codes pass
// through a read state and a write-back state to the report, and the next transaction
// is accepted the cycle after the result is taken. A propagate round first sweeps all
// vertices, reading each flag and degree word, then reads and checks each neighbor
// slot of each changed, unlocked vertex (the flag read is skipped when the stored
// neighbor is out of range), and rereads and writes the vertex when it marks itself.
// It then walks all vertices once to apply the spread marks before the report. After
// reset a clearing pass zeroes the flag and degree words before the first transaction
// is accepted.
`default_nettype none
module lockable_graph_state_spread_top #(
  parameter int unsigned VERTICES   = lgss_pkg::VerticesDef,
  parameter int unsigned MAX_DEGREE = lgss_pkg::MaxDegreeDef
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire lgss_pkg::in_item_t in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output lgss_pkg::out_item_t     out_data
);
  import lgss_pkg::*;

  localparam int unsigned VW = $clog2(VERTICES);
  localparam int unsigned SW = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
  localparam int unsigned NW = VW + SW;
  localparam int unsigned DW = $clog2(MAX_DEGREE + 1);
  localparam int unsigned CW = $clog2(VERTICES + 1);
  localparam int unsigned FW = 4 + DW;
  // Vertex word bits: on, lock, changed, spread, with the degree above them.
  localparam int unsigned B_ON = 0, B_LK = 1, B_CH = 2, B_SP = 3;

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_RD    = 4'd2;
  localparam logic [3:0] S_WB    = 4'd3;
  localparam logic [3:0] S_OUT   = 4'd4;
  localparam logic [3:0] S_PV    = 4'd5;
  localparam logic [3:0] S_PVW   = 4'd6;
  localparam logic [3:0] S_PN    = 4'd7;
  localparam logic [3:0] S_PNW   = 4'd8;
  localparam logic [3:0] S_PNF   = 4'd9;
  localparam logic [3:0] S_AP    = 4'd10;
  localparam logic [3:0] S_APW   = 4'd11;
  localparam logic [3:0] S_SPR   = 4'd12;
  localparam logic [3:0] S_SPW   = 4'd13;

  logic [3:0]      state_r, state_nxt;
  in_item_t        item_r, item_nxt;
  logic [VW:0]     vcnt_r, vcnt_nxt;
  logic [DW-1:0]   k_r, k_nxt;
  logic [DW-1:0]   deg_r, deg_nxt;
  logic [3:0]      vfl_r, vfl_nxt;
  logic [VW-1:0]   nb_r, nb_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [CW-1:0]   pend_r, pend_nxt;
  logic [CW-1:0]   npend_r, npend_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_r, out_nxt;

  // Vertex word memory (flags and degree) and adjacency memory.
  logic          fl_we;
  logic [VW-1:0] fl_wa, fl_ra;
  logic [FW-1:0] fl_wd, fl_rd;
  logic          nt_we;
  logic [NW-1:0] nt_wa, nt_ra;
  logic [7:0]    nt_rd;

  lgss_ram #(.WIDTH(FW), .DEPTH(VERTICES)) u_flags (
    .clk(clk), .we(fl_we), .waddr(fl_wa), .wdata(fl_wd), .raddr(fl_ra), .rdata(fl_rd));
  lgss_ram #(.WIDTH(8), .DEPTH(VERTICES << SW)) u_nbr (
    .clk(clk), .we(nt_we), .waddr(nt_wa), .wdata(item_r.neighbor), .raddr(nt_ra),
    .rdata(nt_rd));

  logic          v_ok;
  logic [VW-1:0] v_idx, c_idx;
  logic          nb_ok;
  logic [DW-1:0] dsat;

  assign v_ok  = ({24'd0, item_r.vertex} < 32'(VERTICES));
  assign v_idx = VW'(item_r.vertex);
  assign c_idx = vcnt_r[VW-1:0];
  assign nb_ok = ({24'd0, nt_rd} < 32'(VERTICES));
  assign dsat  = ({28'd0, item_r.degree_value} > 32'(MAX_DEGREE)) ?
                 DW'(MAX_DEGREE) : DW'(item_r.degree_value);

  assign in_ready  = (state_r == S_IDLE) && !out_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Sequencer: read-modify-write of vertex words, one memory access per port per cycle.
  always_comb begin
    state_nxt = state_r; item_nxt = item_r; vcnt_nxt = vcnt_r; k_nxt = k_r;
    deg_nxt = deg_r; vfl_nxt = vfl_r; nb_nxt = nb_r; count_nxt = count_r;
    pend_nxt = pend_r; npend_nxt = npend_r;
    out_valid_nxt = out_valid_r; out_nxt = out_r;
    fl_we = 1'b0; fl_wa = c_idx; fl_wd = '0; fl_ra = c_idx;
    nt_we = 1'b0;
    nt_wa = {v_idx, SW'(item_r.slot)};
    nt_ra = {c_idx, SW'(k_r)};
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    unique case (state_r)
      S_CLR: begin
        fl_we = 1'b1;
        vcnt_nxt = vcnt_r + 1'b1;
        if (vcnt_r == (VW+1)'(VERTICES - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid && in_ready) begin
          item_nxt = in_data;
          if (in_data.func == FUNC_PROP) begin
            vcnt_nxt = '0; count_nxt = '0; npend_nxt = '0; state_nxt = S_PV;
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      S_RD: begin
        fl_ra = v_idx;
        state_nxt = S_WB;
      end
      S_WB: begin
        vfl_nxt = fl_rd[3:0];
        fl_wa = v_idx; fl_wd = fl_rd;
        if (v_ok) begin
          unique case (item_r.func)
            FUNC_NBR: nt_we = ({29'd0, item_r.slot} < 32'(MAX_DEGREE));
            FUNC_DEG: begin fl_we = 1'b1; fl_wd[FW-1:4] = dsat; end
            FUNC_SET: if (fl_rd[B_ON] != item_r.flag && !fl_rd[B_LK]) begin
              fl_we = 1'b1; fl_wd[B_ON] = item_r.flag; fl_wd[B_CH] = 1'b1;
              vfl_nxt = fl_wd[3:0];
              if (!fl_rd[B_CH]) pend_nxt = pend_r + 1'b1;
            end
            FUNC_LOCK: if (fl_rd[B_LK] != item_r.flag) begin
              fl_we = 1'b1; fl_wd[B_LK] = item_r.flag; fl_wd[B_CH] = 1'b1;
              vfl_nxt = fl_wd[3:0];
              if (!fl_rd[B_CH]) pend_nxt = pend_r + 1'b1;
            end
            default: ;
          endcase
        end
        count_nxt = '0;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        // Report the addressed vertex; for propagate it is reread after apply.
        out_valid_nxt = 1'b1;
        out_nxt.vertex_on       = v_ok & vfl_r[B_ON];
        out_nxt.vertex_locked   = v_ok & vfl_r[B_LK];
        out_nxt.turned_on_count = 9'(count_r);
        out_nxt.work_pending    = (pend_r != '0);
        state_nxt = S_IDLE;
      end
      // Scan phase: read flags and degree of the current vertex.
      S_PV: begin
        if (vcnt_r == (VW+1)'(VERTICES)) begin
          vcnt_nxt = '0; state_nxt = S_AP;
        end else state_nxt = S_PVW;
      end
      S_PVW: begin
        vfl_nxt = fl_rd[3:0]; deg_nxt = fl_rd[FW-1:4]; k_nxt = '0;
        if (fl_rd[B_CH] && !fl_rd[B_LK] && fl_rd[FW-1:4] != '0) state_nxt = S_PN;
        else begin vcnt_nxt = vcnt_r + 1'b1; state_nxt = S_PV; end
      end
      S_PN: state_nxt = S_PNW;   // adjacency read in flight
      S_PNW: begin
        nb_nxt = VW'(nt_rd);
        fl_ra = VW'(nt_rd);
        if (nb_ok) state_nxt = S_PNF;
        else begin
          k_nxt = k_r + 1'b1;
          if (k_r + 1'b1 == deg_r) begin vcnt_nxt = vcnt_r + 1'b1; state_nxt = S_PV; end
          else state_nxt = S_PN;
        end
      end
      S_PNF: begin
        // Neighbor flags are here; decide the spread mark.
        k_nxt = k_r + 1'b1;
        if (k_r + 1'b1 == deg_r) begin
          vcnt_nxt = vcnt_r + 1'b1; state_nxt = S_PV;
        end else state_nxt = S_PN;
        if (!fl_rd[B_LK]) begin
          if (vfl_r[B_ON]) begin
            if (!fl_rd[B_ON]) begin
              fl_we = 1'b1; fl_wa = nb_r; fl_wd = fl_rd; fl_wd[B_SP] = 1'b1;
            end
          end else if (fl_rd[B_ON]) begin
            // The vertex itself spreads; it stays current until its mark is written.
            vcnt_nxt = vcnt_r;
            state_nxt = S_SPR;
          end
        end
      end
      S_SPR: begin
        // Own vertex spreads; reread its word so earlier marks are kept.
        state_nxt = S_SPW;
      end
      S_SPW: begin
        fl_we = 1'b1; fl_wd = fl_rd; fl_wd[B_SP] = 1'b1;
        vcnt_nxt = vcnt_r + 1'b1; state_nxt = S_PV;
      end
      // Apply phase: spread marks become on flags and the new changed set.
      S_AP: begin
        if (vcnt_r == (VW+1)'(VERTICES)) begin
          pend_nxt = npend_r; state_nxt = S_RD;
        end else state_nxt = S_APW;
      end
      S_APW: begin
        fl_we = 1'b1; fl_wd = fl_rd;
        fl_wd[B_CH] = fl_rd[B_SP]; fl_wd[B_SP] = 1'b0;
        if (fl_rd[B_SP]) begin
          fl_wd[B_ON] = 1'b1;
          count_nxt = count_r + 1'b1; npend_nxt = npend_r + 1'b1;
        end
        vcnt_nxt = vcnt_r + 1'b1; state_nxt = S_AP;
      end
      default: state_nxt = S_IDLE;
    endcase
    // Propagate reuses the flag read path; keep its count through S_WB.
    if (state_r == S_WB && item_r.func == FUNC_PROP) count_nxt = count_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR; vcnt_r <= '0; pend_r <= '0; npend_r <= '0;
      count_r <= '0; out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt; vcnt_r <= vcnt_nxt; pend_r <= pend_nxt; npend_r <= npend_nxt;
      count_r <= count_nxt; out_valid_r <= out_valid_nxt;
    end
    item_r <= item_nxt; k_r <= k_nxt; deg_r <= deg_nxt; vfl_r <= vfl_nxt;
    nb_r <= nb_nxt; out_r <= out_nxt;
  end

  // A transaction is never accepted while a result waits.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> !out_valid_r) else $error("accept while result pending");
  // A result is only raised from the report state.
  a_out_from_report: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_OUT) else $error("stray result");
  // Propagate count never exceeds the vertex count.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    {23'd0, count_r} <= 32'(VERTICES)) else $error("count overflow");
endmodule
`default_nettype wire

### rtl/lgss_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
`default_nettype none
module lgss_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### sim/lgss_checker.sv
// Checker that predicts the state spread block's results and compares them field by field.
module lgss_checker (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic                in_ready,
  input  wire lgss_pkg::in_item_t  in_data,
  input  wire logic                out_valid,
  input  wire logic                out_ready,
  input  wire lgss_pkg::out_item_t out_data,
  output int                       fail_count,
  output int                       pending_results,
  output int                       rounds_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import lgss_pkg::*;

  localparam int NV = VerticesDef;
  localparam int ND = MaxDegreeDef;

  // Shadow copy of the block's graph and flag state.
  bit       on_map [NV];
  bit       lock_map [NV];
  bit       changed_map [NV];
  bit [7:0] adjacency [NV*ND];
  bit [3:0] degree_of [NV];

  out_item_t result_queue [$];

  // One propagate round over a snapshot of the flags.
  function automatic int unsigned spread_round();
    bit          marks [NV];
    int unsigned cnt;
    int          n;
    cnt = 0;
    for (int v = 0; v < NV; v++) marks[v] = 0;
    for (int v = 0; v < NV; v++) begin
      if (!changed_map[v] || lock_map[v]) continue;
      for (int k = 0; k < degree_of[v] && k < ND; k++) begin
        n = adjacency[v*ND+k];
        if (n >= NV || lock_map[n]) continue;
        if (on_map[v]) begin
          if (!on_map[n]) marks[n] = 1;
        end else if (on_map[n]) begin
          marks[v] = 1;
          break;
        end
      end
    end
    for (int v = 0; v < NV; v++) begin
      changed_map[v] = marks[v];
      if (marks[v]) begin
        on_map[v] = 1;
        cnt++;
      end
    end
    return cnt;
  endfunction

  // Applies one transaction and returns its expected result.
  function automatic out_item_t predict_flags(in_item_t it);
    out_item_t r;
    int        v;
    v = it.vertex;
    r = '0;
    case (it.func)
      FUNC_NBR: if (it.slot < ND) adjacency[v*ND+it.slot] = it.neighbor;
      FUNC_DEG: degree_of[v] = (it.degree_value > ND) ? 4'(ND) : it.degree_value;
      FUNC_SET: begin
        if (on_map[v] != it.flag && !lock_map[v]) begin
          on_map[v] = it.flag;
          changed_map[v] = 1;
        end
      end
      FUNC_LOCK: begin
        if (lock_map[v] != it.flag) begin
          lock_map[v] = it.flag;
          changed_map[v] = 1;
        end
      end
      FUNC_PROP: r.turned_on_count = 9'(spread_round());
      default: ;
    endcase
    for (int i = 0; i < NV; i++) if (changed_map[i]) r.work_pending = 1;
    r.vertex_on = on_map[v];
    r.vertex_locked = lock_map[v];
    return r;
  endfunction

  // Watch both channels; predict on input, compare on output.
  always @(posedge clk) begin
    out_item_t exp_r;
    if (!rst_n) begin
      fail_count <= 0;
      rounds_seen <= 0;
      pending_results <= 0;
      result_queue.delete();
      for (int i = 0; i < NV; i++) begin
        on_map[i] = 0; lock_map[i] = 0; changed_map[i] = 0; degree_of[i] = 0;
      end
    end else begin
      if (in_valid && in_ready) begin
        result_queue = {result_queue, predict_flags(in_data)};
        if (in_data.func == FUNC_PROP) rounds_seen <= rounds_seen + 1;
      end
      if (out_valid && out_ready) begin
        if (result_queue.size() == 0) begin
          $display("%0t: unexpected result %p", $time, out_data);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = result_queue.pop_front();
          if (exp_r.vertex_on !== out_data.vertex_on ||
              exp_r.vertex_locked !== out_data.vertex_locked ||
              exp_r.turned_on_count !== out_data.turned_on_count ||
              exp_r.work_pending !== out_data.work_pending) begin
            $display("%0t: mismatch expected %p actual %p", $time, exp_r, out_data);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending_results <= result_queue.size();
    end
  end
endmodule

### sim/lockable_graph_state_spread_top_tb.sv
// Testbench top: drives directed and random transactions and reports the verdict.
module lockable_graph_state_spread_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lgss_pkg::*;

  logic      clk, rst_n;
  logic      in_valid, in_ready, out_valid, out_ready;
  in_item_t  in_data;
  out_item_t out_data;
  int        fail_count, pending_results, rounds_seen;
  int        send_idle_pct, recv_stall_pct;
  bit        long_hold;
  bit        written [256*8];
  int        sent_items;

  lockable_graph_state_spread_top u_dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data
  );

  lgss_checker u_checker (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .fail_count, .pending_results, .rounds_seen
  );

  // Free-running clock.
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Receiver with random stalls and an optional long hold-off.
  initial begin
    out_ready = 0;
    forever begin
      @(posedge clk);
      if (long_hold) out_ready <= 0;
      else out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Sends one transaction, with random idle cycles before it. Valid stays high
  // after acceptance so that the next transaction can follow without a gap.
  task automatic send_op(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    sent_items++;
  endtask

  // Builds a transaction; degree writes never expose an unwritten slot.
  task automatic make_op(bit [2:0] f, bit [7:0] v, bit [2:0] s, bit [7:0] nb,
                         bit [3:0] d, bit fl);
    in_item_t it;
    int       lim;
    it = '{func: f, vertex: v, slot: s, neighbor: nb, degree_value: d, flag: fl};
    if (f == FUNC_DEG) begin
      lim = (d > 8) ? 8 : d;
      for (int k = 0; k < lim; k++) if (!written[v*8+k]) begin
        lim = k;
        break;
      end
      if (lim < ((d > 8) ? 8 : d)) it.degree_value = 4'(lim);
    end
    if (f == FUNC_NBR) written[v*8+s] = 1;
    send_op(it);
  endtask

  // Stops offering and waits until every expected result has come.
  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
  endtask

  // Random ops focused on two small clusters of vertices so rounds spread.
  task automatic random_ops(int n);
    bit [7:0] v;
    int       r;
    for (int i = 0; i < n; i++) begin
      v = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(15) + 240 * $urandom_range(1));
      r = $urandom_range(99);
      if (r < 25) make_op(FUNC_NBR, v, 3'($urandom), ($urandom_range(3) == 0) ?
                          8'($urandom) : {v[7:4], 4'($urandom)}, 4'($urandom), 1'($urandom));
      else if (r < 40) make_op(FUNC_DEG, v, 3'($urandom), 8'($urandom), 4'($urandom),
                               1'($urandom));
      else if (r < 60) make_op(FUNC_SET, v, 3'($urandom), 8'($urandom), 4'($urandom),
                               1'($urandom));
      else if (r < 70) make_op(FUNC_LOCK, v, 3'($urandom), 8'($urandom), 4'($urandom),
                               ($urandom_range(3) == 0));
      else if (r < 88) make_op(FUNC_PROP, v, 3'($urandom), 8'($urandom), 4'($urandom),
                               1'($urandom));
      else make_op(3'($urandom_range(7, 5)), v, 3'($urandom), 8'($urandom), 4'($urandom),
                   1'($urandom));
    end
  endtask

  // Stimulus: directed cases, then random phases with varied idling.
  initial begin
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    long_hold = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    sent_items = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1;
    // Directed: a small chain 0-1-2 with 255 as an extreme vertex.
    make_op(FUNC_NBR, 8'd0, 3'd0, 8'd1, 0, 0);
    make_op(FUNC_NBR, 8'd0, 3'd7, 8'd255, 0, 1);
    make_op(FUNC_NBR, 8'd1, 3'd0, 8'd2, 0, 0);
    make_op(FUNC_NBR, 8'd1, 3'd1, 8'd0, 0, 0);
    make_op(FUNC_NBR, 8'd2, 3'd0, 8'd1, 0, 0);
    make_op(FUNC_NBR, 8'd2, 3'd1, 8'd1, 0, 0);
    make_op(FUNC_DEG, 8'd0, 0, 0, 4'd1, 0);
    make_op(FUNC_DEG, 8'd1, 0, 0, 4'd2, 0);
    make_op(FUNC_DEG, 8'd2, 0, 0, 4'd2, 0);
    make_op(FUNC_DEG, 8'd255, 0, 0, 4'd0, 0);
    make_op(FUNC_QUERY, 8'd0, 0, 0, 0, 0);
    make_op(FUNC_SET, 8'd0, 0, 0, 0, 1);
    make_op(FUNC_SET, 8'd0, 0, 0, 0, 1);
    make_op(FUNC_PROP, 8'd1, 0, 0, 0, 0);
    make_op(FUNC_PROP, 8'd2, 0, 0, 0, 0);
    make_op(FUNC_PROP, 8'd2, 0, 0, 0, 0);
    make_op(FUNC_LOCK, 8'd2, 0, 0, 0, 1);
    make_op(FUNC_LOCK, 8'd2, 0, 0, 0, 1);
    make_op(FUNC_SET, 8'd2, 0, 0, 0, 0);
    make_op(FUNC_LOCK, 8'd2, 0, 0, 0, 0);
    make_op(FUNC_SET, 8'd2, 0, 0, 0, 0);
    make_op(FUNC_PROP, 8'd255, 0, 0, 0, 0);
    make_op(3'd6, 8'd1, 3'd7, 8'hff, 4'hf, 1);
    make_op(3'd7, 8'd0, 0, 0, 0, 0);
    drain();
    // Random phases: none, sender idle, receiver stall, both.
    random_ops(60);
    send_idle_pct = 70;
    random_ops(60);
    send_idle_pct = 0;
    recv_stall_pct = 70;
    random_ops(60);
    // Long receiver hold-off while the sender keeps offering.
    recv_stall_pct = 0;
    fork
      begin
        long_hold = 1;
        repeat (3000) @(posedge clk);
        long_hold = 0;
      end
      random_ops(10);
    join
    drain();
    send_idle_pct = 31;
    recv_stall_pct = 31;
    random_ops(60);
    drain();
    repeat (3000) @(posedge clk);
    $display("Ran %0d transactions including %0d propagate rounds over small clusters.",
             sent_items, rounds_seen);
    if (fail_count == 0 && pending_results == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

  // Overall time limit.
  initial begin
    #100ms;
    $display("FAILED: results differ");
    $finish;
  end
endmodule

### files.f
rtl/lgss_pkg.sv
rtl/lgss_ram.sv
rtl/lockable_graph_state_spread_top.sv
sim/lgss_checker.sv
sim/lockable_graph_state_spread_top_tb.sv
